### design/lkvc_pkg.sv
// Package with the shared types and constants of the LRU key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

   // Width of the capacity register and its value after reset.
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request codes carried in req_type.
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } lkvc_state_type;

   // One request transaction.
   typedef struct packed {
      logic               req_type;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } lkvc_req_type;

   // One response transaction.
   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } lkvc_rsp_type;

   // Entry contents that move from one cell to the next.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } lkvc_entry_type;

   // Lookup results accumulated along the row of cells.
   typedef struct packed {
      logic               found;
      logic signed [31:0] hit_value;
      logic signed [31:0] ev_key;
   } lkvc_scan_type;

   // Commands broadcast from the controller to every cell.
   typedef struct packed {
      logic               update;
      logic               evict;
      logic signed [31:0] key;
   } lkvc_ctrl_type;

endpackage

### design/lkvc_cell.sv
// One recency position of the cache: holds an entry and shifts it to the next position.
`timescale 1ns / 1ps

module lkvc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  lkvc_pkg::lkvc_ctrl_type ctrl,
   input  lkvc_pkg::lkvc_entry_type shift_in,
   output lkvc_pkg::lkvc_entry_type shift_out,
   input  lkvc_pkg::lkvc_scan_type scan_in,
   output lkvc_pkg::lkvc_scan_type scan_out
);

   logic               valid_ff;
   logic               valid_in;
   logic signed [31:0] key_ff;
   logic signed [31:0] key_in;
   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               match;
   logic               prev_last;
   logic               shift;

   // Key compare and accumulation of the lookup results.
   always_comb begin
      match     = valid_ff && (key_ff == ctrl.key);
      // The neighbor upstream is the least recent entry when it is valid and this one is not.
      prev_last = shift_in.valid && !valid_ff;
      scan_out.found     = scan_in.found | match;
      scan_out.hit_value = scan_in.hit_value | (match ? value_ff : 32'sd0);
      scan_out.ev_key    = scan_in.ev_key | (prev_last ? shift_in.key : 32'sd0);
   end

   // Cells up to and including the matching one shift by one position.
   always_comb begin
      shift    = ctrl.update && !scan_in.found;
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (shift) begin
         // An evicted entry is dropped as it moves past the end of the occupied region.
         valid_in = shift_in.valid && !(ctrl.evict && prev_last);
         key_in   = shift_in.key;
         value_in = shift_in.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign shift_out.valid = valid_ff;
   assign shift_out.key   = key_ff;
   assign shift_out.value = value_ff;

endmodule

### design/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller, capacity register and row of cells.
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// Requests: drive req_data and raise start; the transaction is taken at a
// clock edge where start is high and busy is low. req_type selects a get or
// a put. Every request produces exactly one response transaction, shown on
// rsp_data for one cycle while rsp_strobe is high; the receiver cannot stall.
// The request executes in the cycle after the edge that takes it, and the
// response is on rsp_data in the cycle after that. While it executes, all
// cells compare the key and shift in parallel and busy is high, so no new
// request is taken until the registered request has executed.
// The entries live in a row of MAX_ENTRIES cells ordered by recency, cell 0
// the most recent; a hit or an insert shifts the cells in front of the
// target by one position, so no separate recency table is kept.
// Configuration: csr_data writes the capacity register (0 acts as 1, values
// above MAX_ENTRIES act as MAX_ENTRIES); csr_ready is always high, write only
// while idle. Reset empties the cache and sets the capacity to 16.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lkvc_pkg::lkvc_req_type     req_data,
   output logic                       rsp_strobe,
   output lkvc_pkg::lkvc_rsp_type     rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_data
);

   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

   lkvc_pkg::lkvc_state_type state_ff;
   lkvc_pkg::lkvc_state_type state_in;
   lkvc_pkg::lkvc_req_type   req_ff;
   logic [OCC_W-1:0]         occ_ff;
   logic [OCC_W-1:0]         occ_in;
   logic [lkvc_pkg::CAP_W-1:0] cap_ff;
   logic                     rsp_strobe_ff;
   lkvc_pkg::lkvc_rsp_type   rsp_ff;
   lkvc_pkg::lkvc_rsp_type   rsp_in;

   logic                     exec;
   logic                     hit;
   logic                     is_put;
   logic                     full;
   logic [CMP_W-1:0]         eff_cap;
   logic signed [31:0]       ev_key;
   lkvc_pkg::lkvc_ctrl_type  ctrl;
   lkvc_pkg::lkvc_entry_type entry_chain [0:MAX_ENTRIES];
   lkvc_pkg::lkvc_scan_type  scan_chain  [0:MAX_ENTRIES];

   // Controller state machine: ST_IDLE takes a request, ST_EXEC executes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      exec     = 1'b0;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = lkvc_pkg::ST_EXEC;
            end
         end
         lkvc_pkg::ST_EXEC: begin
            exec     = 1'b1;
            state_in = lkvc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == lkvc_pkg::ST_EXEC);

   // Request register, loaded when a transaction is taken.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // Capacity register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // Effective capacity clamped to 1..MAX_ENTRIES, and the eviction condition.
   always_comb begin
      eff_cap = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end
      full = (CMP_W'(occ_ff) >= eff_cap);
   end

   // Commands to the cells.
   assign is_put      = (req_ff.req_type == lkvc_pkg::REQ_PUT);
   assign hit         = scan_chain[MAX_ENTRIES].found;
   assign ctrl.update = exec && (hit || is_put);
   assign ctrl.evict  = exec && is_put && !hit && full;
   assign ctrl.key    = req_ff.key;

   // The new most recent entry enters at the head of the row.
   assign entry_chain[0].valid = 1'b1;
   assign entry_chain[0].key   = req_ff.key;
   assign entry_chain[0].value = is_put ? req_ff.value : scan_chain[MAX_ENTRIES].hit_value;

   assign scan_chain[0].found     = 1'b0;
   assign scan_chain[0].hit_value = 32'sd0;
   assign scan_chain[0].ev_key    = 32'sd0;

   // Row of cells in recency order.
   for (genvar p = 0; p < MAX_ENTRIES; p++) begin : g_cell
      lkvc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .shift_in  (entry_chain[p]),
         .shift_out (entry_chain[p+1]),
         .scan_in   (scan_chain[p]),
         .scan_out  (scan_chain[p+1])
      );
   end

   // The last cell of a full row is its own least recent entry.
   assign ev_key = scan_chain[MAX_ENTRIES].ev_key
                   | (entry_chain[MAX_ENTRIES].valid ? entry_chain[MAX_ENTRIES].key : 32'sd0);

   // Occupancy grows only on an insert that does not evict.
   always_comb begin
      occ_in = occ_ff;
      if (exec && is_put && !hit && !full) begin
         occ_in = occ_ff + OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Response register.
   always_comb begin
      rsp_in.hit         = hit;
      rsp_in.evicted     = ctrl.evict;
      rsp_in.evicted_key = ctrl.evict ? ev_key : 32'sd0;
      if (is_put) begin
         rsp_in.read_value = 32'sd0;
      end else if (hit) begin
         rsp_in.read_value = scan_chain[MAX_ENTRIES].hit_value;
      end else begin
         rsp_in.read_value = -32'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
